>>> hw/rtl/cscd_pkg.sv
`default_nettype none

package cscd_pkg;

   // fraction bits of the log2 domain (Q5.26)
   localparam int FRAC_BITS = 26;

   localparam logic [31:0] SAT32      = 32'hFFFF_FFFF;
   localparam logic [16:0] LAMBDA_ONE = 17'h1_0000;

   // configuration register indexes
   localparam logic [1:0] CSR_MAX_DIST = 2'd0;
   localparam logic [1:0] CSR_LAMBDA   = 2'd1;
   localparam logic [1:0] CSR_COUNT    = 2'd2;

   // datapath operations issued by the controller
   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD,
      DP_LOG_INIT,
      DP_LOG_STEP,
      DP_LOG_SAVE,
      DP_FIRST,
      DP_DIV_INIT,
      DP_DIV_STEP,
      DP_DIV_SAVE,
      DP_EXP_STEP,
      DP_EXP_FIN,
      DP_MIX_A,
      DP_MIX_B
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic       sel;
      logic [4:0] cnt;
   } dp_cmd_type;

   typedef logic [31:0] exp_tab_type [FRAC_BITS];

   // integer square root, bit by bit
   function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bit_v;
      v     = v_in;
      res   = '0;
      bit_v = 64'h4000_0000_0000_0000;
      for (int j = 0; j < 32; j++) begin
         if (v >= res + bit_v) begin
            v   = v - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   // factors 2^(2^-k), k = 1.., in Q2.30 by repeated square roots of sqrt(2)
   function automatic exp_tab_type build_exp_tab();
      exp_tab_type tab;
      logic [63:0] c;
      c = isqrt64(64'h1 << 61);
      for (int k = 0; k < FRAC_BITS; k++) begin
         tab[k] = c[31:0];
         c      = isqrt64(c << 30);
      end
      return tab;
   endfunction

   localparam exp_tab_type EXP_TAB = build_exp_tab();

endpackage

`default_nettype wire

>>> hw/rtl/cscd_datapath.sv
`default_nettype none

module cscd_datapath #(
   parameter int MAX_CASCADES = 4,
   parameter int IDXW         = 3
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cscd_pkg::dp_cmd_type    cmd,
   input  wire logic [IDXW-1:0]         cmd_idx,
   input  wire logic [31:0]             near_plane,
   input  wire logic [31:0]             far_plane,
   input  wire logic                    csr_write_enable,
   input  wire logic [1:0]              csr_index,
   input  wire logic [31:0]             csr_write_data,
   output logic [IDXW-1:0]              count,
   output logic [2:0]                   split_index,
   output logic [31:0]                  split_distance,
   output logic                         last_split
);
   import cscd_pkg::*;

   localparam int DWP = ((32 + IDXW + 3) / 4) * 4;

   // configuration
   logic [31:0] max_dist_ff, max_dist_in;
   logic [16:0] lambda_cfg_ff, lambda_cfg_in;
   logic [2:0]  count_cfg_ff, count_cfg_in;

   // captured operands
   logic [31:0]     near_ff, near_in;
   logic [31:0]     range_ff, range_in;
   logic [16:0]     lam_ff, lam_in;
   logic [IDXW-1:0] n_ff, n_in;

   // log2 unit
   logic [30:0] m_ff, m_in;
   logic [25:0] frac_ff, frac_in;
   logic [4:0]  e_ff, e_in;
   logic [30:0] ln_ff, ln_in;
   logic [30:0] lr_ff, lr_in;

   // divider by n
   logic [DWP-1:0]  dvd_ff, dvd_in;
   logic [IDXW-1:0] rem_ff, rem_in;

   // exp2 unit and blend
   logic [30:0] t_ff, t_in;
   logic [31:0] lin_ff, lin_in;
   logic [30:0] y_ff, y_in;
   logic [31:0] lg_ff, lg_in;
   logic [48:0] p1_ff, p1_in;

   // result
   logic [31:0]     dist_ff, dist_in;
   logic [IDXW-1:0] oidx_ff, oidx_in;
   logic            last_ff, last_in;

   // scratch
   logic [31:0]     x_c;
   logic [4:0]      e_c;
   logic [61:0]     m64_c;
   logic [61:0]     sq_c;
   logic [31:0]     s_c;
   logic [31:0]     rng_c;
   logic [3:0]      cnt4_c;
   logic [IDXW-1:0] na_c;
   logic [DWP-1:0]  dq_c;
   logic [IDXW:0]   dr_c;
   logic [63:0]     yp_c;
   logic [63:0]     sh_c;
   logic [49:0]     v_c;

   assign count          = n_ff;
   assign split_index    = 3'(oidx_ff);
   assign split_distance = dist_ff;
   assign last_split     = last_ff;

   always_comb begin
      max_dist_in   = max_dist_ff;
      lambda_cfg_in = lambda_cfg_ff;
      count_cfg_in  = count_cfg_ff;
      near_in  = near_ff;
      range_in = range_ff;
      lam_in   = lam_ff;
      n_in     = n_ff;
      m_in     = m_ff;
      frac_in  = frac_ff;
      e_in     = e_ff;
      ln_in    = ln_ff;
      lr_in    = lr_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      t_in     = t_ff;
      lin_in   = lin_ff;
      y_in     = y_ff;
      lg_in    = lg_ff;
      p1_in    = p1_ff;
      dist_in  = dist_ff;
      oidx_in  = oidx_ff;
      last_in  = last_ff;
      x_c    = '0;
      e_c    = '0;
      m64_c  = '0;
      sq_c   = '0;
      s_c    = '0;
      rng_c  = '0;
      cnt4_c = '0;
      na_c   = '0;
      dq_c   = '0;
      dr_c   = '0;
      yp_c   = '0;
      sh_c   = '0;
      v_c    = '0;

      // configuration writes
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MAX_DIST: max_dist_in   = csr_write_data;
            CSR_LAMBDA:   lambda_cfg_in = csr_write_data[16:0];
            CSR_COUNT:    count_cfg_in  = csr_write_data[2:0];
            default: ;
         endcase
      end

      case (cmd.op)
         // capture request with clamping
         DP_LOAD: begin
            near_in = (near_plane == '0) ? 32'd1 : near_plane;
            rng_c   = (far_plane < max_dist_ff) ? far_plane : max_dist_ff;
            range_in = (rng_c == '0) ? 32'd1 : rng_c;
            lam_in  = (lambda_cfg_ff > LAMBDA_ONE) ? LAMBDA_ONE : lambda_cfg_ff;
            cnt4_c  = 4'(count_cfg_ff);
            if (cnt4_c == '0)
               n_in = IDXW'(1);
            else if (cnt4_c > 4'(MAX_CASCADES))
               n_in = IDXW'(MAX_CASCADES);
            else
               n_in = IDXW'(cnt4_c);
         end
         // normalize mantissa to Q1.30
         DP_LOG_INIT: begin
            x_c = cmd.sel ? range_ff : near_ff;
            for (int b = 0; b < 32; b++) begin
               if (x_c[b])
                  e_c = 5'(b);
            end
            m64_c   = (62'(x_c) << 30) >> e_c;
            m_in    = m64_c[30:0];
            e_in    = e_c;
            frac_in = '0;
         end
         // one fraction bit by squaring
         DP_LOG_STEP: begin
            sq_c = {31'b0, m_ff} * {31'b0, m_ff};
            s_c  = sq_c[61:30];
            if (s_c[31]) begin
               frac_in = {frac_ff[24:0], 1'b1};
               m_in    = s_c[31:1];
            end else begin
               frac_in = {frac_ff[24:0], 1'b0};
               m_in    = s_c[30:0];
            end
         end
         DP_LOG_SAVE: begin
            if (cmd.sel)
               lr_in = {e_ff, frac_ff};
            else
               ln_in = {e_ff, frac_ff};
         end
         // boundary zero is the near plane
         DP_FIRST: begin
            dist_in = near_ff;
            oidx_in = '0;
            last_in = 1'b0;
         end
         // weighted sum to divide by n
         DP_DIV_INIT: begin
            na_c = n_ff - cmd_idx;
            if (cmd.sel)
               dvd_in = DWP'(near_ff) * DWP'(na_c) + DWP'(range_ff) * DWP'(cmd_idx);
            else
               dvd_in = DWP'(ln_ff) * DWP'(na_c) + DWP'(lr_ff) * DWP'(cmd_idx);
            rem_in = '0;
         end
         // four quotient bits per cycle
         DP_DIV_STEP: begin
            dq_c = dvd_ff;
            dr_c = {1'b0, rem_ff};
            for (int j = 0; j < 4; j++) begin
               dr_c = {dr_c[IDXW-1:0], dq_c[DWP-1]};
               dq_c = {dq_c[DWP-2:0], 1'b0};
               if (dr_c >= {1'b0, n_ff}) begin
                  dr_c    = dr_c - {1'b0, n_ff};
                  dq_c[0] = 1'b1;
               end
            end
            dvd_in = dq_c;
            rem_in = dr_c[IDXW-1:0];
         end
         DP_DIV_SAVE: begin
            if (cmd.sel) begin
               lin_in = (|dvd_ff[DWP-1:32]) ? SAT32 : dvd_ff[31:0];
            end else begin
               t_in = dvd_ff[30:0];
               y_in = 31'h4000_0000;
            end
         end
         // multiply in one factor per fraction bit
         DP_EXP_STEP: begin
            if (t_ff[5'(FRAC_BITS - 1) - cmd.cnt]) begin
               yp_c = {33'b0, y_ff} * {32'b0, EXP_TAB[cmd.cnt]};
               y_in = yp_c[60:30];
            end
         end
         // scale by integer part, saturate
         DP_EXP_FIN: begin
            sh_c  = ({33'b0, y_ff} << t_ff[30:26]) >> 30;
            lg_in = (|sh_c[63:32]) ? SAT32 : sh_c[31:0];
         end
         DP_MIX_A: begin
            p1_in = 49'(lam_ff) * 49'(lg_ff);
         end
         // blend, round and saturate
         DP_MIX_B: begin
            v_c = 50'(p1_ff) + 50'(17'(LAMBDA_ONE - lam_ff)) * 50'(lin_ff)
                  + 50'(32768);
            dist_in = (|v_c[49:48]) ? SAT32 : v_c[47:16];
            oidx_in = cmd_idx;
            last_in = (cmd_idx == n_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_dist_ff   <= 32'd6553600;
         lambda_cfg_ff <= 17'd32768;
         count_cfg_ff  <= 3'd3;
      end else begin
         max_dist_ff   <= max_dist_in;
         lambda_cfg_ff <= lambda_cfg_in;
         count_cfg_ff  <= count_cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      near_ff  <= near_in;
      range_ff <= range_in;
      lam_ff   <= lam_in;
      n_ff     <= n_in;
      m_ff     <= m_in;
      frac_ff  <= frac_in;
      e_ff     <= e_in;
      ln_ff    <= ln_in;
      lr_ff    <= lr_in;
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      t_ff     <= t_in;
      lin_ff   <= lin_in;
      y_ff     <= y_in;
      lg_ff    <= lg_in;
      p1_ff    <= p1_in;
      dist_ff  <= dist_in;
      oidx_ff  <= oidx_in;
      last_ff  <= last_in;
   end

endmodule

`default_nettype wire

>>> hw/rtl/cscd_control.sv
`default_nettype none

module cscd_control #(
   parameter int IDXW      = 3,
   parameter int DIV_STEPS = 9
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire logic [IDXW-1:0]      count,
   output cscd_pkg::dp_cmd_type      cmd,
   output logic [IDXW-1:0]           cmd_idx
);
   import cscd_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOG_INIT,
      S_LOG_RUN,
      S_LOG_SAVE,
      S_FIRST,
      S_EMIT,
      S_DIV_INIT,
      S_DIV_RUN,
      S_DIV_SAVE,
      S_EXP_RUN,
      S_EXP_FIN,
      S_MIX_A,
      S_MIX_B
   } state_type;

   state_type       state_ff;
   logic            sel_ff;
   logic [4:0]      cnt_ff;
   logic [IDXW-1:0] idx_ff;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_EMIT);
   assign cmd_idx   = idx_ff;

   // operation for the current step
   always_comb begin
      cmd.sel = sel_ff;
      cmd.cnt = cnt_ff;
      unique case (state_ff)
         S_IDLE:     cmd.op = req_valid ? DP_LOAD : DP_NOP;
         S_LOG_INIT: cmd.op = DP_LOG_INIT;
         S_LOG_RUN:  cmd.op = DP_LOG_STEP;
         S_LOG_SAVE: cmd.op = DP_LOG_SAVE;
         S_FIRST:    cmd.op = DP_FIRST;
         S_DIV_INIT: cmd.op = DP_DIV_INIT;
         S_DIV_RUN:  cmd.op = DP_DIV_STEP;
         S_DIV_SAVE: cmd.op = DP_DIV_SAVE;
         S_EXP_RUN:  cmd.op = DP_EXP_STEP;
         S_EXP_FIN:  cmd.op = DP_EXP_FIN;
         S_MIX_A:    cmd.op = DP_MIX_A;
         S_MIX_B:    cmd.op = DP_MIX_B;
         default:    cmd.op = DP_NOP;
      endcase
   end

   // sequencing
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sel_ff   <= 1'b0;
         cnt_ff   <= '0;
         idx_ff   <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_LOG_INIT;
                  sel_ff   <= 1'b0;
                  idx_ff   <= '0;
               end
            end
            S_LOG_INIT: begin
               state_ff <= S_LOG_RUN;
               cnt_ff   <= '0;
            end
            S_LOG_RUN: begin
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'(FRAC_BITS - 1))
                  state_ff <= S_LOG_SAVE;
            end
            S_LOG_SAVE: begin
               if (sel_ff) begin
                  state_ff <= S_FIRST;
               end else begin
                  sel_ff   <= 1'b1;
                  state_ff <= S_LOG_INIT;
               end
            end
            S_FIRST: state_ff <= S_EMIT;
            S_EMIT: begin
               if (!rsp_stall) begin
                  if (idx_ff == count) begin
                     state_ff <= S_IDLE;
                  end else begin
                     idx_ff   <= idx_ff + IDXW'(1);
                     sel_ff   <= 1'b0;
                     state_ff <= S_DIV_INIT;
                  end
               end
            end
            S_DIV_INIT: begin
               state_ff <= S_DIV_RUN;
               cnt_ff   <= '0;
            end
            S_DIV_RUN: begin
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'(DIV_STEPS - 1))
                  state_ff <= S_DIV_SAVE;
            end
            S_DIV_SAVE: begin
               cnt_ff   <= '0;
               state_ff <= sel_ff ? S_MIX_A : S_EXP_RUN;
            end
            S_EXP_RUN: begin
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'(FRAC_BITS - 1))
                  state_ff <= S_EXP_FIN;
            end
            S_EXP_FIN: begin
               sel_ff   <= 1'b1;
               state_ff <= S_DIV_INIT;
            end
            S_MIX_A: state_ff <= S_MIX_B;
            S_MIX_B: state_ff <= S_EMIT;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/cascade_split_distances_core.sv
`default_nettype none

// Cascade split distances: each request carries a near and far plane (unsigned
// Q16.16) and yields cascade_count+1 responses, split 0 being the near plane and
// split i a lambda-weighted blend of a logarithmic and a linear split, with
// last_split set on the final one. A request runs two 26-step log2 passes at
// the start, then per split two divisions by n at four bits per cycle, a
// 26-step exp2 pass and a blend (MIX_A, then MIX_B), all on one shared
// multiplier-based datapath. New requests are held off until the last
// response of the current one is taken; write configuration only while idle.
module cascade_split_distances_core #(
   parameter int MAX_CASCADES = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_near_plane,
   input  wire logic [31:0] req_far_plane,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_split_index,
   output logic [31:0]      rsp_split_distance,
   output logic             rsp_last_split,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_write_data
);
   import cscd_pkg::*;

   localparam int IDXW      = $clog2(MAX_CASCADES + 1);
   localparam int DIV_STEPS = (32 + IDXW + 3) / 4;

   dp_cmd_type      cmd;
   logic [IDXW-1:0] cmd_idx;
   logic [IDXW-1:0] count;

   cscd_control #(
      .IDXW      (IDXW),
      .DIV_STEPS (DIV_STEPS)
   ) u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .count     (count),
      .cmd       (cmd),
      .cmd_idx   (cmd_idx)
   );

   cscd_datapath #(
      .MAX_CASCADES (MAX_CASCADES),
      .IDXW         (IDXW)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .cmd_idx          (cmd_idx),
      .near_plane       (req_near_plane),
      .far_plane        (req_far_plane),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .count            (count),
      .split_index      (rsp_split_index),
      .split_distance   (rsp_split_distance),
      .last_split       (rsp_last_split)
   );

endmodule

`default_nettype wire

>>> tb/sv/tb_cascade_split_distances_core.sv
`timescale 1ns / 100ps

module tb_cascade_split_distances_core;
   import cscd_pkg::*;

   localparam int MAX_CASCADES_TB = 4;

   typedef struct {
      logic [2:0]  index;
      logic [31:0] distance;
      logic        last;
   } split_type;

   typedef struct {
      logic [31:0] near_plane;
      logic [31:0] far_plane;
   } planes_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_near_plane;
   logic [31:0] req_far_plane;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_split_index;
   logic [31:0] rsp_split_distance;
   logic        rsp_last_split;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [31:0] csr_write_data;

   planes_type  pending_planes[$];
   split_type   expected_splits[$];
   int          error_count = 0;
   int          idle_mode = 0;
   logic        request_taken = 0;
   logic        hold_request = 0;
   int          hold_left = 0;

   // shadow copy of the configuration registers
   logic [31:0] max_distance_q = 32'd6553600;
   logic [16:0] lambda_q = 17'd32768;
   logic [2:0]  count_q = 3'd3;

   cascade_split_distances_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_near_plane(req_near_plane), .req_far_plane(req_far_plane),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_split_index(rsp_split_index), .rsp_split_distance(rsp_split_distance),
      .rsp_last_split(rsp_last_split),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // integer square root, digit by digit
   function automatic logic [63:0] root64(input logic [63:0] value);
      logic [63:0] rem;
      logic [63:0] root;
      logic [63:0] probe;
      rem   = value;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe != 0) begin
         if (rem >= root + probe) begin
            rem  = rem - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   // log2 of a raw value in Q5.26, fraction by repeated squaring
   function automatic logic [63:0] log2_q26(input logic [31:0] x);
      int          top;
      logic [63:0] mant;
      logic [63:0] fraction;
      top = 0;
      fraction = 0;
      for (int b = 0; b < 32; b++)
         if (x[b]) top = b;
      if (top == 31) mant = {32'd0, x} >> 1;
      else mant = {32'd0, x} << (30 - top);
      for (int k = 0; k < 26; k++) begin
         mant = (mant * mant) >> 30;
         fraction = fraction << 1;
         if (mant >= 64'd2 << 30) begin
            fraction[0] = 1'b1;
            mant = mant >> 1;
         end
      end
      return (64'(top) << 26) | fraction;
   endfunction

   // 2^t for t in Q5.26, saturated to 32 bits
   function automatic logic [63:0] exp2_sat(input logic [63:0] t);
      logic [63:0] whole;
      logic [63:0] acc;
      logic [63:0] factor;
      whole  = t >> 26;
      acc    = 64'd1 << 30;
      factor = root64(64'd1 << 61);
      for (int k = 1; k <= 26; k++) begin
         if (t[26 - k]) acc = (acc * factor) >> 30;
         factor = root64(factor << 30);
      end
      if (whole >= 32) return 64'hFFFF_FFFF;
      if (whole >= 30) acc = acc << (whole - 30);
      else acc = acc >> (30 - whole);
      return (acc > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : acc;
   endfunction

   // queue the split boundaries a request should produce
   task automatic compute_splits(input logic [31:0] near_in, input logic [31:0] far_in);
      logic [63:0] nearv;
      logic [63:0] span;
      logic [63:0] weight;
      logic [63:0] cnt;
      logic [63:0] log_near;
      logic [63:0] log_span;
      logic [63:0] log_split;
      logic [63:0] lin_split;
      logic [63:0] blend;
      split_type   s;
      nearv  = (near_in == 0) ? 64'd1 : 64'(near_in);
      span   = (far_in < max_distance_q) ? 64'(far_in) : 64'(max_distance_q);
      if (span == 0) span = 1;
      weight = (lambda_q > LAMBDA_ONE) ? 64'(LAMBDA_ONE) : 64'(lambda_q);
      cnt    = (count_q == 0) ? 64'd1 : (count_q > MAX_CASCADES_TB) ? 64'(MAX_CASCADES_TB)
               : 64'(count_q);
      log_near = log2_q26(nearv[31:0]);
      log_span = log2_q26(span[31:0]);
      s.index = 0; s.distance = nearv[31:0]; s.last = 1'b0;
      expected_splits.push_back(s);
      for (int i = 1; i <= cnt; i++) begin
         log_split = exp2_sat((log_near * (cnt - i) + log_span * i) / cnt);
         lin_split = (nearv * (cnt - i) + span * i) / cnt;
         if (lin_split > 64'hFFFF_FFFF) lin_split = 64'hFFFF_FFFF;
         blend = (weight * log_split + (64'd65536 - weight) * lin_split + 64'd32768) >> 16;
         s.index    = i[2:0];
         s.distance = (blend > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : blend[31:0];
         s.last     = (i == cnt);
         expected_splits.push_back(s);
      end
   endtask

   // request acceptance and prediction
   always @(posedge clock) begin
      request_taken = 1'b0;
      if (!reset && req_valid && !req_stall) begin
         compute_splits(req_near_plane, req_far_plane);
         request_taken = 1'b1;
      end
   end

   // request driver
   always @(negedge clock) begin
      if (!reset && (!req_valid || request_taken)) begin
         if (pending_planes.size() > 0 && !(idle_mode == 0 && $urandom_range(0, 99) < 22)
             && !(idle_mode == 1 && $urandom_range(0, 99) < 51)) begin
            req_near_plane <= pending_planes[0].near_plane;
            req_far_plane  <= pending_planes[0].far_plane;
            void'(pending_planes.pop_front());
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall generator, with a long hold-off on demand
   always @(negedge clock) begin
      if (hold_request && hold_left == 0) begin
         hold_left = 400;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (idle_mode == 0) begin
         rsp_stall <= ($urandom_range(0, 99) < 51);
      end else if (idle_mode == 1) begin
         rsp_stall <= ($urandom_range(0, 99) < 22);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // response checker
   always @(posedge clock) begin
      split_type s;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_splits.size() == 0) begin
            $error("unexpected split: index %0d distance %h", rsp_split_index,
                   rsp_split_distance);
            error_count++;
         end else begin
            s = expected_splits.pop_front();
            if (rsp_split_index !== s.index) begin
               $error("split_index expected %0d actual %0d", s.index, rsp_split_index);
               error_count++;
            end
            if (rsp_split_distance !== s.distance) begin
               $error("split_distance expected %h actual %h", s.distance, rsp_split_distance);
               error_count++;
            end
            if (rsp_last_split !== s.last) begin
               $error("last_split expected %0d actual %0d", s.last, rsp_last_split);
               error_count++;
            end
         end
      end
   end

   task automatic write_csr(input logic [1:0] index, input logic [31:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      case (index)
         CSR_MAX_DIST: max_distance_q = data;
         CSR_LAMBDA:   lambda_q = data[16:0];
         CSR_COUNT:    count_q = data[2:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic add_planes(input logic [31:0] near_in, input logic [31:0] far_in);
      planes_type p;
      p.near_plane = near_in;
      p.far_plane  = far_in;
      pending_planes.push_back(p);
   endtask

   function automatic logic [31:0] random_plane();
      case ($urandom_range(0, 4))
         0: return $urandom();
         1: return $urandom_range(0, 32'h0010_0000);
         2: return $urandom_range(0, 3) == 0 ? 32'd0 : 32'hFFFF_FFFF;
         default: return $urandom_range(32'h0000_1000, 32'h0200_0000);
      endcase
   endfunction

   task automatic drain();
      wait (pending_planes.size() == 0 && !req_valid && expected_splits.size() == 0);
      repeat (20) @(negedge clock);
   endtask

   // stimulus and end of run
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_near_plane = '0;
      req_far_plane = '0;
      rsp_stall = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = CSR_MAX_DIST;
      csr_write_data = '0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // directed: field extremes and special cases under reset settings
      add_planes(32'd0, 32'd6553600);
      add_planes(32'd0, 32'd0);
      add_planes(32'h0001_0000, 32'hFFFF_FFFF);
      add_planes(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_planes(32'h0040_0000, 32'h0001_0000);
      add_planes(32'h0001_0000, 32'h0001_0000);
      add_planes(32'd1, 32'd2);
      add_planes(32'h5555_5555, 32'hAAAA_AAAA);
      add_planes(32'hAAAA_AAAA, 32'h5555_5555);
      drain();
      // lambda above one, full range, most cascades
      write_csr(CSR_MAX_DIST, 32'hFFFF_FFFF);
      write_csr(CSR_LAMBDA, 32'h0001_FFFF);
      write_csr(CSR_COUNT, 32'd7);
      add_planes(32'h0000_8000, 32'hFFFF_FFFF);
      add_planes(32'hFFFF_FFFF, 32'd0);
      add_planes(32'd0, 32'hFFFF_FFFF);
      add_planes(32'h8000_0000, 32'hFFFF_FFFF);
      drain();
      // pure linear, zero cascade count, minimal range, ignored index
      write_csr(CSR_MAX_DIST, 32'd1);
      write_csr(CSR_LAMBDA, 32'd0);
      write_csr(CSR_COUNT, 32'd0);
      write_csr(2'd3, 32'hFFFF_FFFF);
      add_planes(32'd0, 32'hFFFF_FFFF);
      add_planes(32'h0001_0000, 32'h0010_0000);
      add_planes(32'hFFFF_FFFF, 32'd5);
      drain();
      write_csr(CSR_LAMBDA, 32'h0001_0000);
      write_csr(CSR_COUNT, 32'd4);
      write_csr(CSR_MAX_DIST, 32'hFFFF_FFFF);
      add_planes(32'd0, 32'd0);
      add_planes(32'h0000_0001, 32'hFFFF_FFFF);
      add_planes(32'hFFFF_FFFE, 32'h0000_0003);
      drain();

      // random phases with varied settings and idling patterns
      for (int phase = 0; phase < 9; phase++) begin
         idle_mode = phase / 3;
         case ($urandom_range(0, 3))
            0: write_csr(CSR_MAX_DIST, 32'hFFFF_FFFF);
            1: write_csr(CSR_MAX_DIST, $urandom_range(1, 32'h0100_0000));
            2: write_csr(CSR_MAX_DIST, $urandom() | 32'd1);
            default: write_csr(CSR_MAX_DIST, 32'd6553600);
         endcase
         case ($urandom_range(0, 3))
            0: write_csr(CSR_LAMBDA, 32'd0);
            1: write_csr(CSR_LAMBDA, 32'h0001_0000);
            2: write_csr(CSR_LAMBDA, $urandom_range(0, 32'h0001_FFFF));
            default: write_csr(CSR_LAMBDA, $urandom_range(0, 32'h0001_0000));
         endcase
         write_csr(CSR_COUNT, $urandom_range(0, 7));
         if (phase == 1) hold_request = 1'b1;
         for (int n = 0; n < 42; n++)
            add_planes(random_plane(), random_plane());
         drain();
      end

      repeat (400) @(negedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // watchdog
   initial begin
      #8ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
